### rtl/core/ftpm_pkg.sv
// Shared types and constants for the flow table packet matcher.
`default_nettype none
package ftpm_pkg;
  localparam int FlowEntries = 128;
  localparam int IdxW = $clog2(FlowEntries);
  localparam int CntW = $clog2(FlowEntries + 1);
  localparam logic [31:0] WildcardAddr = 32'h0000_0000;
  localparam logic [31:0] LoopbackAddr = 32'h7F00_0001;

  localparam logic [1:0] ModePeer  = 2'd0;
  localparam logic [1:0] ModeLocal = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;

  localparam logic [1:0] MatchFlow = 2'd0;
  localparam logic [1:0] MatchPeer = 2'd1;

  typedef struct packed {
    logic [22:0] proc;
    logic [19:0] desc;
    logic [31:0] peer_addr;
    logic        peer_known;
    logic [15:0] remote_port;
    logic [31:0] local_addr;
    logic        local_known;
    logic [15:0] local_port;
  } slot_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic            load;       // capture the input word
    logic            rd_en;      // issue a table read
    logic [IdxW-1:0] rd_idx;
    logic            eval;       // evaluate the registered read data
    logic            alloc;      // allocate a new slot
    logic            write;      // write back the updated slot
    logic            finish;     // form the result word
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic            key_hit;
    logic            qry_hit;
    logic            ids_ok;
    logic            is_query;
    logic            is_rec;
    logic            peer_drop;
    logic [CntW-1:0] used;
  } dp_stat_t;

  function automatic logic end_match(input logic [31:0] addr, input logic [15:0] port,
                                     input logic known, input logic [31:0] faddr,
                                     input logic [15:0] fport);
    logic r;
    r = 1'b1;
    if (!known && fport == 16'd0) r = 1'b0;
    if (known && addr != faddr) r = 1'b0;
    if (fport != 16'd0 && port != fport) r = 1'b0;
    return r;
  endfunction
endpackage
`default_nettype wire

### rtl/core/ftpm_datapath.sv
// Datapath: slot memory, input word registers, scan evaluation and result.
`default_nettype none
module ftpm_datapath import ftpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  match_mode,
  input  wire logic [1:0]  mode,
  input  wire logic [23:0] process_id,
  input  wire logic [20:0] descriptor,
  input  wire logic [31:0] address_a,
  input  wire logic [15:0] port_a,
  input  wire logic [31:0] address_b,
  input  wire logic [15:0] port_b,
  input  wire ctl_cmd_t    cmd,
  output dp_stat_t         stat,
  output logic             res_matched,
  output logic             res_accepted,
  output logic [6:0]       res_index,
  output logic [7:0]       res_flows
);
  slot_t mem [FlowEntries];
  slot_t rd_data;
  logic [IdxW-1:0] rd_idx_q;

  logic [1:0]  mode_q, mm_q;
  logic [23:0] pid_q;
  logic [20:0] fd_q;
  logic [31:0] aa_q, ab_q;
  logic [15:0] pa_q, pb_q;

  logic [CntW-1:0] used;
  logic [IdxW-1:0] victim;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic            qhit;

  slot_t cur, upd;
  logic  eval_key, eval_q;

  // Table memory, one read port, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data  <= mem[cmd.rd_idx];
      rd_idx_q <= cmd.rd_idx;
    end
    if (cmd.write) mem[hit_idx] <= upd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      mm_q   <= match_mode;
      pid_q  <= process_id;
      fd_q   <= descriptor;
      aa_q   <= address_a;
      pa_q   <= port_a;
      ab_q   <= address_b;
      pb_q   <= port_b;
    end
  end

  assign eval_key = (rd_data.proc == pid_q[22:0]) && (rd_data.desc == fd_q[19:0]);

  always_comb begin
    eval_q = 1'b0;
    if (mm_q == MatchFlow) begin
      if (rd_data.peer_known || rd_data.remote_port != 16'd0) begin
        if (!rd_data.local_known && rd_data.local_port == 16'd0) begin
          eval_q = end_match(aa_q, pa_q, rd_data.peer_known, rd_data.peer_addr,
                             rd_data.remote_port)
                || end_match(ab_q, pb_q, rd_data.peer_known, rd_data.peer_addr,
                             rd_data.remote_port);
        end else begin
          eval_q = (end_match(aa_q, pa_q, rd_data.local_known, rd_data.local_addr,
                              rd_data.local_port)
                 && end_match(ab_q, pb_q, rd_data.peer_known, rd_data.peer_addr,
                              rd_data.remote_port))
                || (end_match(aa_q, pa_q, rd_data.peer_known, rd_data.peer_addr,
                              rd_data.remote_port)
                 && end_match(ab_q, pb_q, rd_data.local_known, rd_data.local_addr,
                              rd_data.local_port));
        end
      end
    end else if (mm_q == MatchPeer) begin
      eval_q = rd_data.peer_known && (rd_data.peer_addr == aa_q || rd_data.peer_addr == ab_q);
    end
  end

  // Scan state, allocation and the working copy of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      victim <= '0;
      hit    <= 1'b0;
      qhit   <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit  <= 1'b0;
        qhit <= 1'b0;
      end
      if (cmd.eval && !hit && !qhit) begin
        if (mode_q == ModeQuery) begin
          qhit <= eval_q;
        end else if (eval_key) begin
          hit     <= 1'b1;
          hit_idx <= rd_idx_q;
          cur     <= rd_data;
        end
      end
      if (cmd.alloc) begin
        hit <= 1'b1;
        cur <= '{proc: pid_q[22:0], desc: fd_q[19:0], default: '0};
        if (used < CntW'(FlowEntries)) begin
          hit_idx <= used[IdxW-1:0];
          used    <= used + 1'b1;
        end else begin
          hit_idx <= victim;
          victim  <= (victim == IdxW'(FlowEntries - 1)) ? '0 : victim + 1'b1;
        end
      end
    end
  end

  always_comb begin
    upd = cur;
    if (mode_q == ModePeer) begin
      if (cur.peer_known && cur.peer_addr != aa_q) begin
        upd.local_known = 1'b0;
        upd.local_addr  = '0;
        upd.local_port  = '0;
      end
      upd.peer_addr  = aa_q;
      upd.peer_known = 1'b1;
      if (pa_q != 16'd0) upd.remote_port = pa_q;
    end else begin
      if (aa_q != WildcardAddr) begin
        upd.local_addr  = aa_q;
        upd.local_known = 1'b1;
      end
      if (pa_q != 16'd0) upd.local_port = pa_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_matched  <= (mode_q == ModeQuery) &&
                      ((mm_q == MatchFlow || mm_q == MatchPeer) ? qhit : 1'b1);
      res_accepted <= cmd.write;
      res_index    <= cmd.write ? 7'(hit_idx) : 7'd0;
      res_flows    <= 8'(used);
    end
  end

  assign stat.key_hit   = hit;
  assign stat.qry_hit   = qhit;
  assign stat.ids_ok    = !pid_q[23] && !fd_q[20];
  assign stat.is_query  = (mode_q == ModeQuery);
  assign stat.is_rec    = (mode_q == ModePeer) || (mode_q == ModeLocal);
  assign stat.peer_drop = (mode_q == ModePeer) && (aa_q == WildcardAddr || aa_q == LoopbackAddr);
  assign stat.used      = used;
endmodule
`default_nettype wire

### rtl/core/ftpm_ctrl.sv
// Controller: sequences the table scan, allocation, write back and output.
`default_nettype none
module ftpm_ctrl import ftpm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DECIDE= 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t          state, state_next;
  logic [CntW-1:0] issued, issued_next;   // reads issued
  logic            pend, pend_next;       // read data in flight
  logic            ovalid;
  logic            scan_hit;
  logic            write_do, write_do_next;

  assign scan_hit = stat.is_query ? stat.qry_hit : stat.key_hit;
  assign in_stall = !(state == S_IDLE) || (ovalid && out_stall);
  assign out_valid = ovalid;

  always_comb begin
    state_next    = state;
    issued_next   = issued;
    pend_next     = 1'b0;
    write_do_next = write_do;
    cmd           = '0;
    cmd.rd_idx    = issued[IdxW-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        issued_next   = '0;
        write_do_next = 1'b0;
        if (stat.is_query || (stat.is_rec && stat.ids_ok && !stat.peer_drop))
          state_next = S_SCAN;
        else
          state_next = S_DONE;
        if (stat.is_query && !(stat.used != '0)) state_next = S_DONE;
      end
      S_SCAN: begin
        // one slot read issued per cycle; evaluate the previous one
        cmd.eval = pend;
        if (!scan_hit && !(pend && 1'b0) && issued < stat.used) begin
          cmd.rd_en   = 1'b1;
          issued_next = issued + 1'b1;
          pend_next   = 1'b1;
        end else if (!pend) begin
          state_next = S_DECIDE;
        end
        if (scan_hit) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.is_rec) begin
          write_do_next = 1'b1;
          cmd.alloc     = !stat.key_hit;
          state_next    = S_WRITE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      issued   <= '0;
      pend     <= 1'b0;
      ovalid   <= 1'b0;
      write_do <= 1'b0;
    end else begin
      state    <= state_next;
      issued   <= issued_next;
      pend     <= pend_next;
      write_do <= write_do_next;
      if (cmd.finish) ovalid <= 1'b1;
      else if (!out_stall) ovalid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.write |-> write_do)
    else $error("write back without a record decision");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_CHECK)
    else $error("loaded word not checked");
  assert property (@(posedge clk) disable iff (rst) cmd.rd_en |-> issued < stat.used)
    else $error("read beyond occupied slots");
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> !(ovalid && out_stall))
    else $error("result overwritten while stalled");
endmodule
`default_nettype wire

### rtl/core/flow_table_packet_matcher.sv
// Top level of the flow table packet matcher.
// Input channel: in_valid / in_stall with fields mode, process_id, descriptor,
// address_a, port_a, address_b, port_b. A word is taken at a clock edge with
// in_valid high and in_stall low.
// Output channel: out_valid / out_stall with fields matched, accepted,
// entry_index, flows_in_use; exactly one result word per input word.
// Config: cfg_wr_en / cfg_wr_data write match_mode; write only while idle.
// One word is processed at a time. The table sits in a single-port-read
// memory and is scanned one slot per cycle. The next input word is taken
// no earlier than the forming of the result word for the one before;
// a key found early or a matching query ends the scan early.
// Reset (rst, synchronous) empties the table and the round-robin pointer;
// no clearing pass is needed because only occupied slots are read.
// When the receiver stalls, the result word holds and no new input word is
// taken until the result has been delivered.
`default_nettype none
module flow_table_packet_matcher import ftpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [23:0] process_id,
  input  wire logic [20:0] descriptor,
  input  wire logic [31:0] address_a,
  input  wire logic [15:0] port_a,
  input  wire logic [31:0] address_b,
  input  wire logic [15:0] port_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             matched,
  output logic             accepted,
  output logic [6:0]       entry_index,
  output logic [7:0]       flows_in_use
);
  logic [1:0] match_mode;
  ctl_cmd_t   cmd;
  dp_stat_t   stat;

  // Hold the filter mode register.
  always_ff @(posedge clk) begin
    if (rst) match_mode <= MatchFlow;
    else if (cfg_wr_en) match_mode <= cfg_wr_data;
  end

  ftpm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  ftpm_datapath u_dp (
    .clk, .rst, .match_mode, .mode, .process_id, .descriptor,
    .address_a, .port_a, .address_b, .port_b, .cmd, .stat,
    .res_matched(matched), .res_accepted(accepted),
    .res_index(entry_index), .res_flows(flows_in_use)
  );
endmodule
`default_nettype wire

### tb/sv/flow_table_packet_matcher_test.sv
// Self-checking testbench for the flow table packet matcher.
`timescale 1ns / 1ps
`default_nettype none
module flow_table_packet_matcher_test;
  import ftpm_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam logic [1:0] MatchAll = 2'd2;
  localparam logic [1:0] MatchUnused = 2'd3;
  localparam int SettleCycles = 300;

  typedef struct packed {
    logic       matched;
    logic       accepted;
    logic [6:0] entry_index;
    logic [7:0] flows_in_use;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = '0;
  logic [23:0] process_id = '0;
  logic [20:0] descriptor = '0;
  logic [31:0] address_a = '0;
  logic [15:0] port_a = '0;
  logic [31:0] address_b = '0;
  logic [15:0] port_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic matched;
  logic accepted;
  logic [6:0] entry_index;
  logic [7:0] flows_in_use;

  always #1 clk = ~clk;

  flow_table_packet_matcher u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .process_id(process_id), .descriptor(descriptor), .address_a(address_a),
    .port_a(port_a), .address_b(address_b), .port_b(port_b),
    .out_valid(out_valid), .out_stall(out_stall), .matched(matched),
    .accepted(accepted), .entry_index(entry_index), .flows_in_use(flows_in_use)
  );

  // Shadow copy of the connection table, as the block should hold it.
  slot_t shadow_slot [FlowEntries];
  int unsigned shadow_used;
  int unsigned shadow_victim;
  logic [1:0] shadow_match_mode;

  verdict_t pending_verdicts[$];
  int unsigned error_count;
  bit hold_off_request;

  // Pool of keys kept small so records hit existing connections often.
  logic [23:0] key_proc_pool [16];
  logic [20:0] key_desc_pool [16];
  logic [31:0] addr_pool [8];

  function automatic bit end_fits(logic [31:0] pkt_addr, logic [15:0] pkt_port,
                                  logic known, logic [31:0] st_addr,
                                  logic [15:0] st_port);
    if (!known && st_port == 16'd0) return 1'b0;
    if (known && pkt_addr != st_addr) return 1'b0;
    if (st_port != 16'd0 && pkt_port != st_port) return 1'b0;
    return 1'b1;
  endfunction

  // Find the slot of a key, allocating (or replacing round-robin) when absent.
  function automatic int find_or_claim(logic [23:0] pid, logic [20:0] fd);
    int idx;
    if (pid[23] || fd[20]) return -1;
    for (int i = 0; i < shadow_used; i++)
      if (shadow_slot[i].proc == pid[22:0] && shadow_slot[i].desc == fd[19:0]) return i;
    if (shadow_used < FlowEntries) begin
      idx = shadow_used;
      shadow_used++;
    end else begin
      idx = shadow_victim;
      shadow_victim = (shadow_victim + 1) % FlowEntries;
    end
    shadow_slot[idx] = '0;
    shadow_slot[idx].proc = pid[22:0];
    shadow_slot[idx].desc = fd[19:0];
    return idx;
  endfunction

  function automatic bit flow_hit(logic [31:0] sa, logic [15:0] sp,
                                  logic [31:0] da, logic [15:0] dp);
    slot_t f;
    for (int i = 0; i < shadow_used; i++) begin
      f = shadow_slot[i];
      if (!f.peer_known && f.remote_port == 16'd0) continue;
      if (!f.local_known && f.local_port == 16'd0) begin
        if (end_fits(sa, sp, f.peer_known, f.peer_addr, f.remote_port) ||
            end_fits(da, dp, f.peer_known, f.peer_addr, f.remote_port)) return 1'b1;
        continue;
      end
      if (end_fits(sa, sp, f.local_known, f.local_addr, f.local_port) &&
          end_fits(da, dp, f.peer_known, f.peer_addr, f.remote_port)) return 1'b1;
      if (end_fits(sa, sp, f.peer_known, f.peer_addr, f.remote_port) &&
          end_fits(da, dp, f.local_known, f.local_addr, f.local_port)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(logic [1:0] m, logic [23:0] pid,
                                               logic [20:0] fd, logic [31:0] aa,
                                               logic [15:0] pa, logic [31:0] ab,
                                               logic [15:0] pb);
    verdict_t v;
    int s;
    v = '0;
    if (m == ModePeer) begin
      if (aa != WildcardAddr && aa != LoopbackAddr) begin
        s = find_or_claim(pid, fd);
        if (s >= 0) begin
          // A moved peer invalidates the cached local end.
          if (shadow_slot[s].peer_known && shadow_slot[s].peer_addr != aa) begin
            shadow_slot[s].local_known = 1'b0;
            shadow_slot[s].local_addr = '0;
            shadow_slot[s].local_port = '0;
          end
          shadow_slot[s].peer_addr = aa;
          shadow_slot[s].peer_known = 1'b1;
          if (pa != 16'd0) shadow_slot[s].remote_port = pa;
          v.accepted = 1'b1;
          v.entry_index = s[6:0];
        end
      end
    end else if (m == ModeLocal) begin
      s = find_or_claim(pid, fd);
      if (s >= 0) begin
        if (aa != WildcardAddr) begin
          shadow_slot[s].local_addr = aa;
          shadow_slot[s].local_known = 1'b1;
        end
        if (pa != 16'd0) shadow_slot[s].local_port = pa;
        v.accepted = 1'b1;
        v.entry_index = s[6:0];
      end
    end else if (m == ModeQuery) begin
      if (shadow_match_mode == MatchFlow) begin
        v.matched = flow_hit(aa, pa, ab, pb);
      end else if (shadow_match_mode == MatchPeer) begin
        for (int i = 0; i < shadow_used; i++)
          if (shadow_slot[i].peer_known &&
              (shadow_slot[i].peer_addr == aa || shadow_slot[i].peer_addr == ab))
            v.matched = 1'b1;
      end else begin
        v.matched = 1'b1;
      end
    end
    v.flows_in_use = shadow_used[7:0];
    return v;
  endfunction

  // Offer one word, hold it until taken, then predict its verdict.
  // Valid stays high, so a word sent right behind follows without a gap unless a random gap is drawn.
  task automatic send_word(logic [1:0] m, logic [23:0] pid, logic [20:0] fd,
                           logic [31:0] aa, logic [15:0] pa, logic [31:0] ab,
                           logic [15:0] pb);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    process_id <= pid;
    descriptor <= fd;
    address_a <= aa;
    port_a <= pa;
    address_b <= ab;
    port_b <= pb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(m, pid, fd, aa, pa, ab, pb));
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write match_mode only while the block is idle.
  task automatic set_match_mode(logic [1:0] val);
    drain_verdicts();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_match_mode = val;
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return WildcardAddr;
      1: return LoopbackAddr;
      2, 3: return $urandom();
      default: return addr_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($urandom());
      default: return 16'd1000 + 16'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic random_word(int key_span);
    int k;
    logic [1:0] m;
    logic [23:0] pid;
    logic [20:0] fd;
    k = $urandom_range(0, key_span - 1);
    pid = key_proc_pool[k % 16] + 24'(k / 16);
    fd = key_desc_pool[k % 16];
    // Occasionally use unknown ids or an unused mode, or fully random words.
    if ($urandom_range(0, 19) == 0) pid = 24'h800000 | 24'($urandom());
    if ($urandom_range(0, 19) == 0) fd = 21'h100000 | 21'($urandom());
    if ($urandom_range(0, 29) == 0) begin
      pid = 24'($urandom());
      fd = 21'($urandom());
    end
    m = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 39) == 0) m = ModeUnused;
    send_word(m, pid, fd, pick_addr(), pick_port(), pick_addr(), pick_port());
  endtask

  task automatic test_directed();
    send_word(ModeQuery, 24'd1, 21'd1, 32'h0A000001, 16'd80, 32'h0A000002, 16'd81);
    send_word(ModePeer, 24'hFFFFFF, 21'd3, 32'h0A000001, 16'd80, '0, '0);
    send_word(ModePeer, 24'd3, 21'h1FFFFF, 32'h0A000001, 16'd80, '0, '0);
    send_word(ModePeer, 24'd5, 21'd7, WildcardAddr, 16'd80, '0, '0);
    send_word(ModePeer, 24'd5, 21'd7, LoopbackAddr, 16'd80, '0, '0);
    send_word(ModePeer, 24'd5, 21'd7, 32'h0A000001, 16'd0, '0, '0);
    send_word(ModeQuery, '0, '0, 32'h0A000001, 16'd1, 32'hFFFFFFFF, 16'd2);
    send_word(ModePeer, 24'd5, 21'd7, 32'h0A000001, 16'hFFFF, '1, '1);
    send_word(ModeLocal, 24'd5, 21'd7, WildcardAddr, 16'd0, '0, '0);
    send_word(ModeLocal, 24'd5, 21'd7, WildcardAddr, 16'd443, '0, '0);
    send_word(ModeQuery, '0, '0, 32'h01020304, 16'd443, 32'h0A000001, 16'hFFFF);
    send_word(ModeLocal, 24'd5, 21'd7, 32'hC0A80001, 16'd443, '0, '0);
    send_word(ModeQuery, '0, '0, 32'h0A000001, 16'hFFFF, 32'hC0A80001, 16'd443);
    send_word(ModeQuery, '0, '0, 32'hC0A80001, 16'd443, 32'h0A000001, 16'hFFFF);
    send_word(ModePeer, 24'd5, 21'd7, 32'h0A000009, 16'd0, '0, '0);
    send_word(ModeQuery, '0, '0, 32'hC0A80001, 16'd443, 32'h0A000009, 16'hFFFF);
    send_word(ModeLocal, 24'h7FFFFF, 21'hFFFFF, 32'hFFFFFFFF, 16'hFFFF, '0, '0);
    send_word(ModeQuery, '0, '0, '0, '0, '0, '0);
    send_word(ModeUnused, 24'd5, 21'd7, 32'h0A000001, 16'd1, '0, '0);
    send_word(ModeQuery, '1, '1, '1, '1, '1, '1);
  endtask

  task automatic test_match_modes();
    logic [1:0] setting [4];
    setting[0] = MatchPeer;
    setting[1] = MatchAll;
    setting[2] = MatchUnused;
    setting[3] = MatchFlow;
    for (int s = 0; s < 4; s++) begin
      set_match_mode(setting[s]);
      repeat (30) random_word(24);
    end
  endtask

  // Overflow the table so round-robin replacement wraps at least once.
  task automatic test_table_full();
    for (int i = 0; i < 300; i++)
      send_word(ModePeer, 24'h100 + 24'(i), 21'(i), 32'h0B000000 + 32'(i % 5 + 1),
                16'(i), '0, '0);
    repeat (20) random_word(24);
  endtask

  // Stall the output long enough that the input backs up.
  task automatic test_backpressure();
    hold_off_request = 1'b1;
    repeat (8) random_word(24);
  endtask

  task automatic test_random();
    for (int n = 0; n < 140; n++) begin
      if (n == 70) set_match_mode(2'($urandom_range(0, 1)));
      random_word(($urandom_range(0, 3) == 0) ? 200 : 24);
    end
    set_match_mode(MatchFlow);
  endtask

  // Result checker: compare each delivered word with the oldest prediction.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{matched, accepted, entry_index, flows_in_use};
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.matched !== want.matched)
          $display("%0t: matched expected %b actual %b", $time, want.matched, got.matched);
        if (got.accepted !== want.accepted)
          $display("%0t: accepted expected %b actual %b", $time, want.accepted,
                   got.accepted);
        if (got.entry_index !== want.entry_index)
          $display("%0t: entry_index expected %0d actual %0d", $time, want.entry_index,
                   got.entry_index);
        if (got.flows_in_use !== want.flows_in_use)
          $display("%0t: flows_in_use expected %0d actual %0d", $time, want.flows_in_use,
                   got.flows_in_use);
        if (got !== want) error_count++;
      end
    end
  end

  // Receiver stall: random gaps, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_off_request) begin
      hold_off_request <= 1'b0;
      out_stall <= 1'b1;
      repeat (600) @(posedge clk);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3))
        @(posedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    error_count = 0;
    hold_off_request = 1'b0;
    shadow_used = 0;
    shadow_victim = 0;
    shadow_match_mode = MatchFlow;
    foreach (shadow_slot[i]) shadow_slot[i] = '0;
    for (int i = 0; i < 16; i++) begin
      key_proc_pool[i] = 24'($urandom_range(0, 24'h7FFFFF));
      key_desc_pool[i] = 21'($urandom_range(0, 21'hFFFFF));
    end
    key_proc_pool[0] = 24'h7FFFFF;
    key_desc_pool[0] = 21'hFFFFF;
    key_proc_pool[1] = '0;
    key_desc_pool[1] = '0;
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
    addr_pool[0] = 32'hFFFFFFFF;
    addr_pool[1] = 32'h00000001;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_match_mode(MatchFlow);
    test_directed();
    test_match_modes();
    test_backpressure();
    drain_verdicts();
    test_random();
    test_table_full();
    test_match_modes();
    drain_verdicts();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/core/ftpm_pkg.sv
rtl/core/ftpm_datapath.sv
rtl/core/ftpm_ctrl.sv
rtl/core/flow_table_packet_matcher.sv
tb/sv/flow_table_packet_matcher_test.sv
